>>> src/stepper_phase_sequencer_macros.svh
// ============================================================================
// Stepper phase sequencer assertion macros
// Shared property shorthands for the sequencer RTL. Each macro expects clk and
// rst_n to be visible in the scope where it is used.
// ============================================================================
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sps_pkg.sv
// ============================================================================
// Stepper phase sequencer package
// Widths, codes and coil pattern tables shared by the sequencer files.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    localparam int PosBits  = 32;
    localparam int PosW     = 32;
    localparam int StepW    = 32;
    localparam int DelayW   = 32;
    localparam int PhaseW   = 3;
    localparam int CoilW    = 4;
    localparam int FuncW    = 2;
    localparam int StatusW  = 2;
    localparam int ModeW    = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int LimW     = 64;

    localparam logic signed [LimW-1:0] PosMax = (64'sd1 <<< (PosBits - 1)) - 64'sd1;
    localparam logic signed [LimW-1:0] PosMin = -PosMax - 64'sd1;

    localparam logic [FuncW-1:0] FUNC_TICK = 2'd0;
    localparam logic [FuncW-1:0] FUNC_REL  = 2'd1;
    localparam logic [FuncW-1:0] FUNC_ABS  = 2'd2;

    localparam logic [StatusW-1:0] STAT_TICK   = 2'd0;
    localparam logic [StatusW-1:0] STAT_ACCEPT = 2'd1;
    localparam logic [StatusW-1:0] STAT_BUSY   = 2'd2;
    localparam logic [StatusW-1:0] STAT_RANGE  = 2'd3;

    localparam logic [ModeW-1:0] MODE_WAVE = 2'd0;
    localparam logic [ModeW-1:0] MODE_FULL = 2'd1;
    localparam logic [ModeW-1:0] MODE_HALF = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_STEP_MODE   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CW_FORWARD  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_POS     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MAX_POS     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STEP_DELAY  = 3'd4;

    localparam logic [CoilW-1:0] WAVE_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [CoilW-1:0] FULL_TAB [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [CoilW-1:0] HALF_TAB [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    // Modes with the upper bit set use the eight-entry half-step table.
    function automatic logic [CoilW-1:0] pattern_at(input logic [ModeW-1:0] mode,
                                                    input logic [PhaseW-1:0] idx);
        logic [CoilW-1:0] pat;
        if (mode[1]) begin
            pat = HALF_TAB[idx];
        end else if (mode == MODE_WAVE) begin
            pat = WAVE_TAB[idx[1:0]];
        end else begin
            pat = FULL_TAB[idx[1:0]];
        end
        return pat;
    endfunction

    function automatic logic [PhaseW-1:0] table_last(input logic [ModeW-1:0] mode);
        return mode[1] ? 3'd7 : 3'd3;
    endfunction

endpackage

`default_nettype wire

>>> src/sps_cmd_if.sv
// ============================================================================
// Stepper command channel
// Valid/ready channel that carries tick and move items into the sequencer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface sps_cmd_if;
    import sps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FuncW-1:0]        func;
    logic signed [PosW-1:0]  move_amount;

    modport source (output valid, output func, output move_amount, input ready);
    modport sink   (input valid, input func, input move_amount, output ready);
endinterface

`default_nettype wire

>>> src/sps_res_if.sv
// ============================================================================
// Stepper result channel
// Valid/ready channel that carries one result per command item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface sps_res_if;
    import sps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CoilW-1:0]        coils;
    logic                    coils_changed;
    logic [StatusW-1:0]      status;
    logic                    done_res;
    logic signed [PosW-1:0]  start_position;
    logic signed [PosW-1:0]  stop_position;
    logic signed [PosW-1:0]  position;
    logic                    busy_res;

    modport source (output valid, output coils, output coils_changed, output status,
                    output done_res, output start_position, output stop_position,
                    output position, output busy_res, input ready);
    modport sink   (input valid, input coils, input coils_changed, input status,
                    input done_res, input start_position, input stop_position,
                    input position, input busy_res, output ready);
endinterface

`default_nettype wire

>>> src/stepper_phase_sequencer.sv
// ============================================================================
// Stepper phase sequencer
// Four-coil unipolar stepper sequencer with wave, full and half step tables,
// relative and absolute moves, position limits and a tick-driven step delay.
// ============================================================================
//
//   Channel   Direction  Payload
//   -------   ---------  ---------------------------------------------------
//   cmd       in         func, move_amount
//   res       out        coils, coils_changed, status, done_res,
//                        start_position, stop_position, position, busy_res
//   cfg       in         cfg_wr_en, cfg_index, cfg_data (write only)
//
// Items are taken one per clock unless stalled, via input and result registers.
// The rate is set by the single compute stage between the input register and
// the result register, which also updates the move state.
// Reset clears the move state and loads the default register values.
// A result that is not taken stalls the compute stage, and cmd.ready falls once
// the input register is full as well.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_phase_sequencer_macros.svh"

module stepper_phase_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sps_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [sps_pkg::CfgDataW-1:0]   cfg_data,
    sps_cmd_if.sink                        cmd,
    sps_res_if.source                      res
);
    import sps_pkg::*;

    logic [ModeW-1:0]         step_mode_reg;
    logic                     cw_fwd_reg;
    logic signed [PosW-1:0]   min_pos_reg;
    logic signed [PosW-1:0]   max_pos_reg;
    logic [DelayW-1:0]        step_delay_reg;

    logic                     in_valid_reg;
    logic [FuncW-1:0]         in_func_reg;
    logic signed [PosW-1:0]   in_amount_reg;

    logic signed [PosW-1:0]   position_reg, position_next;
    logic                     busy_reg, busy_next;
    logic                     turn_fwd_reg, turn_fwd_next;
    logic [PhaseW-1:0]        phase_reg, phase_next;
    logic [StepW-1:0]         steps_done_reg, steps_done_next;
    logic [StepW-1:0]         steps_total_reg, steps_total_next;
    logic [DelayW-1:0]        delay_reg, delay_next;
    logic signed [PosW-1:0]   move_start_reg, move_start_next;
    logic signed [PosW-1:0]   move_end_reg, move_end_next;
    logic [CoilW-1:0]         coil_reg, coil_next;

    logic                     res_valid_reg;
    logic                     res_changed_reg, changed_next;
    logic [StatusW-1:0]       res_status_reg, status_next;
    logic                     res_done_reg, done_next;

    logic                     advance;
    logic                     in_ready;
    logic                     fire;

    logic                     is_move;
    logic                     is_rel;
    logic signed [PosW:0]     pos_ext;
    logic signed [PosW:0]     amt_ext;
    logic signed [PosW:0]     target;
    logic signed [LimW-1:0]   target_wide;
    logic signed [PosW:0]     min_ext;
    logic signed [PosW:0]     max_ext;
    logic                     range_ok;
    logic signed [PosW:0]     diff_up;
    logic signed [PosW:0]     diff_dn;
    logic [StepW-1:0]         step_count;
    logic                     zero_move;
    logic                     pos_dir;
    logic                     turn_fwd_new;
    logic [PhaseW-1:0]        tab_last;

    logic [DelayW-1:0]        delay_inc;
    logic                     expire;
    logic [PhaseW-1:0]        idx;
    logic                     wrap;
    logic [PhaseW-1:0]        phase_step;
    logic [StepW-1:0]         steps_done_inc;
    logic                     finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mode_reg  <= MODE_FULL;
            cw_fwd_reg     <= 1'b1;
            min_pos_reg    <= {1'b1, {(PosW-1){1'b0}}};
            max_pos_reg    <= {1'b0, {(PosW-1){1'b1}}};
            step_delay_reg <= DelayW'(1000);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_STEP_MODE:  step_mode_reg  <= cfg_data[ModeW-1:0];
                CFG_CW_FORWARD: cw_fwd_reg     <= cfg_data[0];
                CFG_MIN_POS:    min_pos_reg    <= cfg_data[PosW-1:0];
                CFG_MAX_POS:    max_pos_reg    <= cfg_data[PosW-1:0];
                CFG_STEP_DELAY: step_delay_reg <= cfg_data[DelayW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign advance   = !res_valid_reg || res.ready;
    assign in_ready  = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && in_ready)
        begin
            in_func_reg   <= cmd.func;
            in_amount_reg <= cmd.move_amount;
        end
    end

    assign is_rel  = (in_func_reg == FUNC_REL);
    assign is_move = is_rel || (in_func_reg == FUNC_ABS);
    assign pos_ext = {position_reg[PosW-1], position_reg};
    assign amt_ext = {in_amount_reg[PosW-1], in_amount_reg};
    assign min_ext = {min_pos_reg[PosW-1], min_pos_reg};
    assign max_ext = {max_pos_reg[PosW-1], max_pos_reg};
    assign target  = is_rel ? pos_ext + amt_ext : amt_ext;
    assign target_wide = LimW'(target);
    assign range_ok = (target >= min_ext) && (target <= max_ext) &&
                      (target_wide >= PosMin) && (target_wide <= PosMax);

    // For a relative move the step count is the magnitude of the amount.
    assign diff_up    = is_rel ? amt_ext : amt_ext - pos_ext;
    assign diff_dn    = is_rel ? -amt_ext : pos_ext - amt_ext;
    assign zero_move  = (diff_up == '0);
    assign pos_dir    = !diff_up[PosW] && !zero_move;
    assign step_count = diff_up[PosW] ? diff_dn[StepW-1:0] : diff_up[StepW-1:0];
    assign turn_fwd_new = (pos_dir == cw_fwd_reg);
    assign tab_last   = table_last(step_mode_reg);

    assign delay_inc      = delay_reg + DelayW'(1);
    assign expire         = (delay_inc >= step_delay_reg);
    assign idx            = phase_reg & tab_last;
    assign wrap           = turn_fwd_reg ? (idx == tab_last) : (idx == '0);
    assign steps_done_inc = steps_done_reg + StepW'(1);
    assign finish         = wrap && (steps_done_inc >= steps_total_reg);

    always_comb
    begin
        if (turn_fwd_reg)
        begin
            phase_step = wrap ? '0 : idx + PhaseW'(1);
        end
        else
        begin
            phase_step = wrap ? tab_last : idx - PhaseW'(1);
        end
    end

    always_comb
    begin
        position_next    = position_reg;
        busy_next        = busy_reg;
        turn_fwd_next    = turn_fwd_reg;
        phase_next       = phase_reg;
        steps_done_next  = steps_done_reg;
        steps_total_next = steps_total_reg;
        delay_next       = delay_reg;
        move_start_next  = move_start_reg;
        move_end_next    = move_end_reg;
        coil_next        = coil_reg;
        changed_next     = 1'b0;
        status_next      = STAT_TICK;
        done_next        = 1'b0;

        if (is_move)
        begin
            if (busy_reg)
            begin
                status_next = STAT_BUSY;
            end
            else if (!range_ok)
            begin
                status_next = STAT_RANGE;
            end
            else
            begin
                status_next      = STAT_ACCEPT;
                turn_fwd_next    = turn_fwd_new;
                phase_next       = turn_fwd_new ? '0 : tab_last;
                steps_done_next  = '0;
                steps_total_next = step_count;
                delay_next       = '0;
                move_start_next  = position_reg;
                move_end_next    = target[PosW-1:0];
                busy_next        = !zero_move;
                done_next        = zero_move;
            end
        end
        else if (busy_reg)
        begin
            if (expire)
            begin
                delay_next   = '0;
                coil_next    = pattern_at(step_mode_reg, idx);
                changed_next = 1'b1;
                phase_next   = phase_step;
                if (wrap)
                begin
                    steps_done_next = steps_done_inc;
                end
                if (finish)
                begin
                    busy_next     = 1'b0;
                    position_next = move_end_reg;
                    done_next     = 1'b1;
                end
            end
            else
            begin
                delay_next = delay_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            busy_reg        <= 1'b0;
            turn_fwd_reg    <= 1'b0;
            phase_reg       <= '0;
            steps_done_reg  <= '0;
            steps_total_reg <= '0;
            delay_reg       <= '0;
            move_start_reg  <= '0;
            move_end_reg    <= '0;
            coil_reg        <= '0;
        end
        else if (fire)
        begin
            position_reg    <= position_next;
            busy_reg        <= busy_next;
            turn_fwd_reg    <= turn_fwd_next;
            phase_reg       <= phase_next;
            steps_done_reg  <= steps_done_next;
            steps_total_reg <= steps_total_next;
            delay_reg       <= delay_next;
            move_start_reg  <= move_start_next;
            move_end_reg    <= move_end_next;
            coil_reg        <= coil_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_changed_reg <= changed_next;
            res_status_reg  <= status_next;
            res_done_reg    <= done_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.coils          = coil_reg;
    assign res.coils_changed  = res_changed_reg;
    assign res.status         = res_status_reg;
    assign res.done_res       = res_done_reg;
    assign res.start_position = move_start_reg;
    assign res.stop_position  = move_end_reg;
    assign res.position       = position_reg;
    assign res.busy_res       = busy_reg;

    `SPS_ASSERT_NOW(a_busy_steps, busy_reg, steps_done_reg < steps_total_reg, "Step count reached total while busy.")
    `SPS_ASSERT_NOW(a_stop_position, $fell(busy_reg), position_reg == move_end_reg, "Position not updated at move end.")
    `SPS_ASSERT_NOW(a_ready_empty, !res_valid_reg, cmd.ready, "Command not ready with an empty result register.")
    `SPS_ASSERT_NEXT(a_fire_loads, in_valid_reg && advance, res_valid_reg, "Computed item did not reach the result register.")

endmodule

`default_nettype wire
